// ===== hdl/mibd_pkg.sv =====
// Package for the MOV instruction byte decoder: decode phase type, opcode
// constants and the decoded record struct shared by the decode, result register, core and checker modules.
// No dependencies.
`default_nettype none

package mibd_pkg;

  // Decode phase: which byte of the instruction is expected next
  typedef enum logic [2:0] {
    PH_OPCODE,
    PH_IMM_LO,
    PH_IMM_HI,
    PH_MODRM,
    PH_DISP_LO,
    PH_DISP_HI
  } mibd_phase_e;

  // Opcode patterns
  localparam logic [5:0] OPC_RM_MOV  = 6'b100010;  // 100010dw
  localparam logic [3:0] OPC_IMM_MOV = 4'b1011;    // 1011wrrr
  localparam logic [2:0] RM_DIRECT   = 3'b110;

  // mod field codes
  localparam logic [1:0] MOD_MEM    = 2'b00;
  localparam logic [1:0] MOD_DISP8  = 2'b01;
  localparam logic [1:0] MOD_DISP16 = 2'b10;
  localparam logic [1:0] MOD_REG    = 2'b11;

  // form codes
  localparam logic FORM_RM  = 1'b0;
  localparam logic FORM_IMM = 1'b1;

  // One decoded result record
  typedef struct packed {
    logic        error;
    logic [15:0] error_offset;
    logic        form;
    logic        wide;
    logic        direction;
    logic [1:0]  mode;
    logic [2:0]  reg_field;
    logic [2:0]  rm_field;
    logic        direct_address;
    logic [15:0] displacement;
    logic [15:0] immediate;
  } mibd_rec_t;

endpackage

`default_nettype wire

// ===== hdl/mibd_in_reg.sv =====
// Input register of the MOV byte decoder: holds one code byte until the
// decode stage takes it. Depends on nothing.
`default_nettype none

module mibd_in_reg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] code_byte_i,
  input  wire logic       take_i,
  output logic            valid_o,
  output logic [7:0]      byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  // Free when empty or when the held byte leaves this cycle
  assign in_ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= code_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

// ===== hdl/mibd_decode.sv =====
// Decode stage of the MOV byte decoder: phase state machine, saved opcode,
// mod/reg/rm and low-byte registers, byte counter and record build.
// Depends on mibd_pkg.
`default_nettype none

module mibd_decode
  import mibd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  output logic            emit_o,
  output mibd_rec_t       rec_o
);

  mibd_phase_e phase_q, phase_d;
  logic [5:0]  opc_q;
  logic [7:0]  modrm_q;
  logic [7:0]  lo_q;
  logic [15:0] count_q, count_d;

  logic is_imm_opc, is_rm_opc, byte_needs_disp;

  function automatic mibd_rec_t mk_imm(logic [5:0] opc, logic [15:0] value);
    mibd_rec_t r;
    r           = '0;
    r.form      = FORM_IMM;
    r.wide      = opc[3];
    r.reg_field = opc[2:0];
    r.immediate = value;
    return r;
  endfunction

  function automatic mibd_rec_t mk_rm(logic [5:0] opc, logic [7:0] modrm,
                                      logic [15:0] disp);
    mibd_rec_t r;
    r                = '0;
    r.form           = FORM_RM;
    r.wide           = opc[0];
    r.direction      = opc[1];
    r.mode           = modrm[7:6];
    r.reg_field      = modrm[5:3];
    r.rm_field       = modrm[2:0];
    r.direct_address = (modrm[7:6] == MOD_MEM) && (modrm[2:0] == RM_DIRECT);
    r.displacement   = disp;
    return r;
  endfunction

  assign is_imm_opc = (byte_i[7:4] == OPC_IMM_MOV);
  assign is_rm_opc  = (byte_i[7:2] == OPC_RM_MOV);
  assign byte_needs_disp = (byte_i[7:6] == MOD_DISP8) || (byte_i[7:6] == MOD_DISP16) ||
                           ((byte_i[7:6] == MOD_MEM) && (byte_i[2:0] == RM_DIRECT));
  assign count_d = count_q + 16'd1;

  // Next phase
  always_comb begin
    phase_d = PH_OPCODE;
    unique case (phase_q)
      PH_IMM_LO: begin
        if (opc_q[3]) phase_d = PH_IMM_HI;
      end
      PH_MODRM: begin
        if (byte_needs_disp) phase_d = PH_DISP_LO;
      end
      PH_DISP_LO: begin
        if (modrm_q[7:6] != MOD_DISP8) phase_d = PH_DISP_HI;
      end
      PH_IMM_HI, PH_DISP_HI: begin
        phase_d = PH_OPCODE;
      end
      PH_OPCODE: begin
        if (is_imm_opc) begin
          phase_d = PH_IMM_LO;
        end else if (is_rm_opc) begin
          phase_d = PH_MODRM;
        end
      end
      default: begin
        phase_d = PH_OPCODE;
      end
    endcase
  end

  // Record and emit flag
  always_comb begin
    emit_o = 1'b0;
    rec_o  = '0;
    unique case (phase_q)
      PH_IMM_LO: begin
        if (!opc_q[3]) begin
          emit_o = 1'b1;
          rec_o  = mk_imm(opc_q, {8'h00, byte_i});
        end
      end
      PH_IMM_HI: begin
        emit_o = 1'b1;
        rec_o  = mk_imm(opc_q, {byte_i, lo_q});
      end
      PH_MODRM: begin
        if (!byte_needs_disp) begin
          emit_o = 1'b1;
          rec_o  = mk_rm(opc_q, byte_i, 16'h0000);
        end
      end
      PH_DISP_LO: begin
        if (modrm_q[7:6] == MOD_DISP8) begin
          emit_o = 1'b1;
          rec_o  = mk_rm(opc_q, modrm_q, {{8{byte_i[7]}}, byte_i});
        end
      end
      PH_DISP_HI: begin
        emit_o = 1'b1;
        rec_o  = mk_rm(opc_q, modrm_q, {byte_i, lo_q});
      end
      PH_OPCODE: begin
        if (!is_imm_opc && !is_rm_opc) begin
          emit_o             = 1'b1;
          rec_o.error        = 1'b1;
          rec_o.error_offset = count_d;
        end
      end
      default: begin
        emit_o = 1'b0;
      end
    endcase
  end

  // State update on each consumed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OPCODE;
      opc_q   <= '0;
      modrm_q <= '0;
      lo_q    <= '0;
      count_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      if ((phase_q == PH_OPCODE) && (is_imm_opc || is_rm_opc)) opc_q <= byte_i[5:0];
      if (phase_q == PH_MODRM) modrm_q <= byte_i;
      if ((phase_q == PH_IMM_LO) || (phase_q == PH_DISP_LO)) lo_q <= byte_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mibd_out_reg.sv =====
// Result register of the MOV byte decoder: holds one decoded record until
// the downstream side takes it. Depends on mibd_pkg.
`default_nettype none

module mibd_out_reg
  import mibd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,
  input  wire mibd_rec_t rec_i,
  output logic           can_load_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output mibd_rec_t      rec_o
);

  logic      valid_q;
  mibd_rec_t rec_q;

  // Room when empty or when the held record transfers this cycle
  assign can_load_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_load_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load_o && load_i) begin
      rec_q <= rec_i;
    end
  end

  assign out_valid_o = valid_q;
  assign rec_o       = rec_q;

endmodule

`default_nettype wire

// ===== hdl/mov_instruction_byte_decoder_core.sv =====
// MOV instruction byte decoder. Takes one 8086 code byte per transfer and
// emits one record when a MOV immediate-to-register or register/memory MOV
// is complete, or an error record for an unknown opcode. Throughput is one
// byte per clock; a byte passes the input register, the decode logic and
// the result register, so a record is offered once its last byte has left
// the input register. Bytes stall only while a record waits unaccepted in
// the result register. Depends on mibd_pkg, mibd_in_reg, mibd_decode,
// mibd_out_reg.
`default_nettype none

module mov_instruction_byte_decoder_core
  import mibd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  code_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             error_o,
  output logic [15:0]      error_offset_o,
  output logic             form_o,
  output logic             wide_o,
  output logic             direction_o,
  output logic [1:0]       mode_o,
  output logic [2:0]       reg_field_o,
  output logic [2:0]       rm_field_o,
  output logic             direct_address_o,
  output logic [15:0]      displacement_o,
  output logic [15:0]      immediate_o
);

  logic      byte_valid;
  logic [7:0] byte_q;
  logic      can_load;
  logic      step;
  logic      emit;
  mibd_rec_t dec_rec;
  mibd_rec_t out_rec;

  // A byte is consumed whenever the result register could take its record
  assign step = byte_valid && can_load;

  mibd_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .code_byte_i (code_byte_i),
    .take_i      (step),
    .valid_o     (byte_valid),
    .byte_o      (byte_q)
  );

  mibd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (byte_q),
    .emit_o (emit),
    .rec_o  (dec_rec)
  );

  mibd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && emit),
    .rec_i       (dec_rec),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rec_o       (out_rec)
  );

  assign error_o          = out_rec.error;
  assign error_offset_o   = out_rec.error_offset;
  assign form_o           = out_rec.form;
  assign wide_o           = out_rec.wide;
  assign direction_o      = out_rec.direction;
  assign mode_o           = out_rec.mode;
  assign reg_field_o      = out_rec.reg_field;
  assign rm_field_o       = out_rec.rm_field;
  assign direct_address_o = out_rec.direct_address;
  assign displacement_o   = out_rec.displacement;
  assign immediate_o      = out_rec.immediate;

endmodule

`default_nettype wire

// ===== hdl/mibd_checker.sv =====
// Port-level checks for the MOV byte decoder and the bind that attaches
// them to mov_instruction_byte_decoder_core. Depends on mibd_pkg.
`default_nettype none

module mibd_checker
  import mibd_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        error_o,
  input wire logic [15:0] error_offset_o,
  input wire logic        form_o,
  input wire logic        wide_o,
  input wire logic        direction_o,
  input wire logic [1:0]  mode_o,
  input wire logic [2:0]  reg_field_o,
  input wire logic [2:0]  rm_field_o,
  input wire logic        direct_address_o,
  input wire logic [15:0] displacement_o,
  input wire logic [15:0] immediate_o
);

  // A stalled record stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Error records carry nothing but the offset
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> (form_o == 1'b0) && !wide_o && !direction_o &&
      (mode_o == 2'b00) && (reg_field_o == 3'b000) && (rm_field_o == 3'b000) &&
      !direct_address_o && (displacement_o == 16'h0000) && (immediate_o == 16'h0000))
    else $error("error record has decoded fields");

  // Good records have no offset
  a_good_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !error_o |-> (error_offset_o == 16'h0000))
    else $error("good record has an error offset");

  // Immediate form leaves the mod/rm side clear, byte immediates are narrow
  a_imm_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !error_o && (form_o == FORM_IMM) |-> !direction_o &&
      (mode_o == 2'b00) && (rm_field_o == 3'b000) && !direct_address_o &&
      (displacement_o == 16'h0000) && (wide_o || (immediate_o[15:8] == 8'h00)))
    else $error("immediate record malformed");

  // Register/memory form: no immediate, direct address flag and no-disp cases
  a_rm_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !error_o && (form_o == FORM_RM) |-> (immediate_o == 16'h0000) &&
      (direct_address_o == ((mode_o == MOD_MEM) && (rm_field_o == RM_DIRECT))) &&
      (((mode_o != MOD_REG) && !((mode_o == MOD_MEM) && (rm_field_o != RM_DIRECT)))
        || (displacement_o == 16'h0000)))
    else $error("register/memory record malformed");

endmodule

bind mov_instruction_byte_decoder_core mibd_checker u_mibd_checker (.*);

`default_nettype wire
